// ----- rtl/dht_pkg.sv -----
// Shared types, codes and hash helpers for the double hash table.
package dht_pkg;

    localparam int KEY_W  = 31;
    localparam int PAY_W  = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int SIZE_W = 7;   // table size register and slot numbers
    localparam int CNT_W  = 8;   // probe read counter, runs from zero up to size plus one
    localparam int REM_W  = 5;   // residues mod 17 and the probe step
    localparam int NIB_N  = 8;   // nibbles in the padded 32-bit key

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [REM_W-1:0]  HASH_MOD   = 5'd17;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FOLD,
        S_REDUCE,
        S_PROBE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clr;
        logic load_in;
        logic hash;
        logic fold;
        logic reduce;
        logic probe_init;
        logic probe;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic red_done;
        logic eval_done;
        logic out_free;
    } t_dp_sts;

    // (16*rem + nib) mod 17; 16 is -1 mod 17, so this is (nib - rem) mod 17
    function automatic logic [REM_W-1:0] f_rem_step(input logic [REM_W-1:0] rem,
                                                    input logic [3:0] nib);
        logic [5:0] v;
        v = {2'b00, nib} + 6'd17 - {1'b0, rem};
        if (v >= 6'd17) begin
            v = v - 6'd17;
        end
        return v[REM_W-1:0];
    endfunction

    // (5*rem + 7) mod 17 for rem below 17
    function automatic logic [REM_W-1:0] f_home_hash(input logic [REM_W-1:0] rem);
        logic [6:0] v;
        v = {rem, 2'b00} + {2'b00, rem} + 7'd7;
        for (int i = 0; i < 5; i++) begin
            if (v >= 7'd17) begin
                v = v - 7'd17;
            end
        end
        return v[REM_W-1:0];
    endfunction

endpackage

// ----- rtl/dht_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
module dht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dht_ctrl.sv -----
// Sequencing state machine for the double hash table.
module dht_ctrl
    import dht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_sts.hash_last) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD:   n_state = S_REDUCE;
            S_REDUCE: begin
                if (i_sts.red_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.eval_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_HASH:   o_cmd.hash = 1'b1;
            S_FOLD:   o_cmd.fold = 1'b1;
            S_REDUCE: begin
                o_cmd.probe_init = i_sts.red_done;
                o_cmd.reduce     = !i_sts.red_done;
            end
            S_PROBE:  o_cmd.probe = 1'b1;
            S_FINISH: o_cmd.out_load = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ----- rtl/dht_datapath.sv -----
// Hashing, probe addressing, table memories and result register.
module dht_datapath
    import dht_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SIZE_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [PAY_W-1:0]   i_payload,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [PAY_W-1:0]   o_payload_out
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SMAX = (DEPTH < 127) ? DEPTH : 127;
    localparam logic [SIZE_W-1:0] SMAX_V = SIZE_W'(SMAX);

    logic [SIZE_W-1:0] r_table_size;
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [PAY_W-1:0]  r_pay;
    logic [31:0]       r_kshift;
    logic [2:0]        r_nib_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [SIZE_W-1:0] r_home;
    logic [REM_W-1:0]  r_step;
    logic [SIZE_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_valid;
    logic [SIZE_W-1:0] r_rd_slot;
    logic              r_rd_home;
    logic              r_rd_last;
    logic              r_found;
    logic [STAT_W-1:0] r_status;
    logic [PAY_W-1:0]  r_result;
    logic [AW-1:0]     r_clr_addr;
    logic              r_o_valid;
    logic [STAT_W-1:0] r_o_status;
    logic [PAY_W-1:0]  r_o_payload;

    logic [SIZE_W-1:0] size_eff;
    logic              home_ge;
    logic              step_ge;
    logic [SIZE_W-1:0] step_ext;
    logic [SIZE_W:0]   addr_sum;
    logic [SIZE_W:0]   addr_next;
    logic              issue_en;

    logic [KEY_W:0]    key_q;
    logic [PAY_W-1:0]  pay_q;
    logic              occ;
    logic              kmatch;
    logic              eval;
    logic              hit;
    logic              done;
    logic [STAT_W-1:0] stat;
    logic [PAY_W-1:0]  res;

    logic              key_we;
    logic [AW-1:0]     key_waddr;
    logic [KEY_W:0]    key_wdata;
    logic              pay_we;
    logic [PAY_W-1:0]  pay_wdata;

    // effective size: zero acts as one, capped at the memory depth and at 127
    always_comb begin
        if (r_table_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_table_size > SMAX_V) begin
            size_eff = SMAX_V;
        end else begin
            size_eff = r_table_size;
        end
    end

    assign step_ext  = {2'b00, r_step};
    assign home_ge   = (r_home >= size_eff);
    assign step_ge   = (step_ext >= size_eff);
    assign addr_sum  = {1'b0, r_addr} + {1'b0, step_ext};
    assign addr_next = (addr_sum >= {1'b0, size_eff}) ? addr_sum - {1'b0, size_eff}
                                                      : addr_sum;
    // home read plus one read per probe: size+1 reads in all
    assign issue_en  = i_cmd.probe && (r_cnt <= {1'b0, size_eff});

    // probe evaluation on the word returned by the memories
    assign occ    = key_q[KEY_W];
    assign kmatch = occ && (key_q[KEY_W-1:0] == r_key);
    assign eval   = i_cmd.probe && r_rd_valid;

    always_comb begin
        hit  = 1'b0;
        done = 1'b1;
        stat = STAT_MISS;
        res  = '0;
        unique case (r_op)
            OP_INSERT: begin
                hit  = !occ;
                done = hit || r_rd_last;
                stat = hit ? STAT_OK : STAT_FULL;
            end
            OP_SEARCH: begin
                hit  = kmatch;
                done = hit || r_rd_last;
                stat = hit ? STAT_OK : STAT_MISS;
                res  = hit ? pay_q : '0;
            end
            OP_DELETE: begin
                // a home match stops; otherwise sweep every probe
                hit  = kmatch;
                done = (hit && r_rd_home) || r_rd_last;
                stat = (hit || r_found) ? STAT_OK : STAT_MISS;
            end
            default: begin
                hit  = 1'b0;
                done = 1'b1;
                stat = STAT_MISS;
            end
        endcase
    end

    // memory write ports
    always_comb begin
        key_we    = 1'b0;
        key_waddr = AW'(r_rd_slot);
        key_wdata = {1'b1, r_key};
        pay_we    = 1'b0;
        pay_wdata = r_pay;
        if (i_cmd.clr) begin
            key_we    = 1'b1;
            key_waddr = r_clr_addr;
            key_wdata = '0;
        end else if (eval && hit && (r_op == OP_INSERT)) begin
            key_we = 1'b1;
            pay_we = 1'b1;
        end else if (eval && hit && (r_op == OP_DELETE)) begin
            pay_we    = 1'b1;
            pay_wdata = '0;
        end
    end

    dht_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (AW'(r_addr)),
        .o_rdata (key_q)
    );

    dht_ram #(
        .WIDTH (PAY_W),
        .DEPTH (DEPTH)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (AW'(r_rd_slot)),
        .i_wdata (pay_wdata),
        .i_raddr (AW'(r_addr)),
        .o_rdata (pay_q)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
            r_clr_addr   <= '0;
            r_rd_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_rd_valid <= issue_en;
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op      <= i_opcode;
            r_key     <= i_key;
            r_pay     <= i_payload;
            r_kshift  <= {1'b0, i_key};
            r_nib_cnt <= '0;
            r_rem     <= '0;
        end
        if (i_cmd.hash) begin
            r_rem     <= f_rem_step(r_rem, r_kshift[31:28]);
            r_kshift  <= {r_kshift[27:0], 4'h0};
            r_nib_cnt <= r_nib_cnt + 3'd1;
        end
        if (i_cmd.fold) begin
            r_home <= SIZE_W'(f_home_hash(r_rem));
            r_step <= HASH_MOD - r_rem;
        end
        if (i_cmd.reduce) begin
            if (home_ge) begin
                r_home <= r_home - size_eff;
            end
            if (step_ge) begin
                r_step <= REM_W'(step_ext - size_eff);
            end
        end
        if (i_cmd.probe_init) begin
            r_addr  <= r_home;
            r_cnt   <= '0;
            r_found <= 1'b0;
        end
        if (issue_en) begin
            r_rd_slot <= r_addr;
            r_rd_home <= (r_cnt == '0);
            r_rd_last <= (r_cnt == {1'b0, size_eff});
            r_cnt     <= r_cnt + CNT_W'(1);
            r_addr    <= addr_next[SIZE_W-1:0];
        end
        if (eval && hit && (r_op == OP_DELETE)) begin
            r_found <= 1'b1;
        end
        if (eval && done) begin
            r_status <= stat;
            r_result <= res;
        end
        if (i_cmd.out_load) begin
            r_o_status  <= r_status;
            r_o_payload <= r_result;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.hash_last = (r_nib_cnt == 3'(NIB_N - 1));
    assign o_sts.red_done  = !home_ge && !step_ge;
    assign o_sts.eval_done = eval && done;
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_payload_out = r_o_payload;

endmodule

// ----- rtl/double_hash_table.sv -----
// Top level of the double hash table: controller, datapath and checks.
//
// Open-addressed table of key/payload pairs with double hashing. Each word on
// the input channel is one request (insert, search or delete) and yields
// exactly one result word. One request is worked at a time: the key is
// reduced mod 17 four bits per cycle, folded into a home slot and a probe
// step, both brought below the table size by repeated subtraction (a long
// run only for very small sizes), then the home slot and all size probes are
// read back to back through the single read port of the key memory, one slot
// per cycle. Insert stops early on the first free slot, search on the first
// match, and delete only on a match in the home slot. The result is then
// handed over, and the block returns to idle before the next word is taken.
// The result sits in an output register, so a finished word may wait there
// while the next request is accepted. After reset the block sweeps the
// occupied marks clear, one slot per cycle, through all DEPTH slots before it
// accepts its first request; table_size writes are taken during that sweep
// as always. The user must write table_size through i_cfg_we/i_cfg_wdata only
// while the block is idle; the block itself does not enforce this. Zero acts
// as one and values above DEPTH act as DEPTH.
module double_hash_table
    import dht_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [SIZE_W-1:0]  i_cfg_wdata,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [PAY_W-1:0]   i_payload,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [PAY_W-1:0]   o_payload_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dht_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_payload_out (o_payload_out)
    );

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // the controller issues at most one datapath command per cycle
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

    // a result only appears when the controller hands one over
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.out_load))
        else $error("result word without a finished request");

    // no request is taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr |-> !o_in_ready)
        else $error("request accepted during clearing sweep");

endmodule

// ----- tb/sv/double_hash_table_test.sv -----
// Self-checking testbench for double_hash_table: random and directed requests, scoreboard.
module double_hash_table_test;
    import dht_pkg::*;

    // Opcode 3 is not defined by the block; it must answer a miss and change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int TBL_DEPTH   = 64;
    localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either channel
    localparam int HOLD_CYCLES = 400;   // long back-pressure on the result channel
    localparam int DRAIN_WAIT  = 100;   // a bit more than one worst-case request
    localparam int POOL_N      = 32;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } request_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [PAY_W-1:0]  payload;
    } answer_t;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_opcode    = OP_SEARCH;
    logic [KEY_W-1:0]  i_key       = '0;
    logic [PAY_W-1:0]  i_payload   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [PAY_W-1:0]  o_payload_out;

    double_hash_table #(.DEPTH(TBL_DEPTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_payload_out (o_payload_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table. Key and payload entries are only looked at
    // when the slot's occupied mark is set, so their X start value is harmless.
    // ------------------------------------------------------------------
    bit                slot_used [TBL_DEPTH];
    logic [KEY_W-1:0]  slot_key  [TBL_DEPTH];
    logic [PAY_W-1:0]  slot_pay  [TBL_DEPTH];
    int unsigned       size_reg = SIZE_RESET;   // raw register value, 0..127

    request_t   req_backlog[$];    // words waiting for the driver
    answer_t    answers_due[$];    // predicted result words, oldest first
    logic [KEY_W-1:0] key_pool[POOL_N];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_go       = 1'b0;   // asks the monitor for one long stall
    int  hold_cnt      = 0;
    int  n_bad         = 0;
    int  quiet_cycles  = 0;

    function automatic bit slot_holds(int slot, logic [KEY_W-1:0] k);
        return slot_used[slot] && slot_key[slot] == k;
    endfunction

    // Applies one request to the shadow table and returns the result word
    // the block must produce for it.
    function automatic answer_t table_apply(request_t rq);
        answer_t          ans;
        longint unsigned  kk;
        int               s;
        int               home;
        int               step;
        int               p;
        int               slot;
        bit               done;
        kk   = rq.key;
        // zero acts as one, anything past the depth as the full depth
        s    = (size_reg == 0) ? 1 : (size_reg > TBL_DEPTH) ? TBL_DEPTH : size_reg;
        // 5k+7 must not wrap before the mod 17
        home = int'(((kk * 5 + 7) % 17) % s);
        step = 17 - int'(kk % 17);
        ans.status  = STAT_MISS;
        ans.payload = '0;
        done = 1'b0;
        case (rq.op)
            OP_INSERT: begin
                ans.status = STAT_FULL;
                slot = home;
                if (!slot_used[home]) begin
                    ans.status = STAT_OK;
                end else begin
                    for (int i = 0; i < s && !done; i++) begin
                        p = (home + (i + 1) * step) % s;
                        if (!slot_used[p]) begin
                            slot = p;
                            ans.status = STAT_OK;
                            done = 1'b1;
                        end
                    end
                end
                // no duplicate check: the same key may land in several slots
                if (ans.status == STAT_OK) begin
                    slot_used[slot] = 1'b1;
                    slot_key[slot]  = rq.key;
                    slot_pay[slot]  = rq.pay;
                end
            end
            OP_SEARCH: begin
                if (slot_holds(home, rq.key)) begin
                    ans.status  = STAT_OK;
                    ans.payload = slot_pay[home];
                end else begin
                    for (int i = 0; i < s && !done; i++) begin
                        p = (home + (i + 1) * step) % s;
                        if (slot_holds(p, rq.key)) begin
                            ans.status  = STAT_OK;
                            ans.payload = slot_pay[p];
                            done = 1'b1;
                        end
                    end
                end
            end
            OP_DELETE: begin
                // a home hit clears only the home slot; otherwise every
                // matching slot on the probe path loses its payload
                if (slot_holds(home, rq.key)) begin
                    ans.status = STAT_OK;
                    slot_pay[home] = '0;
                end else begin
                    for (int i = 0; i < s; i++) begin
                        p = (home + (i + 1) * step) % s;
                        if (slot_holds(p, rq.key)) begin
                            ans.status  = STAT_OK;
                            slot_pay[p] = '0;
                        end
                    end
                end
            end
            default: ;  // unused opcode: miss, table untouched
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers request words from the backlog. Valid stays up with the
    // word unchanged until it is taken; the prediction is made at the edge
    // where the word is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        request_t rq;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rq.op  = i_opcode;
                rq.key = i_key;
                rq.pay = i_payload;
                answers_due.push_back(table_apply(rq));
            end
            if (!i_in_valid || o_in_ready) begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    rq = req_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode   <= rq.op;
                    i_key      <= rq.key;
                    i_payload  <= rq.pay;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result word against the oldest prediction and
    // drives ready, including the one long hold-off when asked.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        answer_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    $error("result word with nothing expected: status %0d payload_out %0h",
                           o_status, o_payload_out);
                    n_bad++;
                end else begin
                    want = answers_due.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        n_bad++;
                    end
                    if (o_payload_out !== want.payload) begin
                        $error("payload_out: expected %0h, actual %0h",
                               want.payload, o_payload_out);
                        n_bad++;
                    end
                end
            end
            if (hold_go && hold_cnt < HOLD_CYCLES) begin
                hold_cnt    <= hold_cnt + 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: nothing moving on either channel for too long means a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        request_t rq;
        rq.op  = op;
        rq.key = k;
        rq.pay = p;
        req_backlog.push_back(rq);
    endtask

    // Every request yields one result, so once all are back the block is idle.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_in_valid || answers_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_size(logic [SIZE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        size_reg     = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(99) < 60)
            return key_pool[$urandom_range(POOL_N - 1)];
        return r[KEY_W-1:0];
    endfunction

    function automatic logic [PAY_W-1:0] pick_pay();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 15) return '1;
        return $urandom;
    endfunction

    // Mostly insert/search/search runs on one key, half with a delete before the last search, so that hits happen,
    // mixed with loose single requests, random keys and the unused opcode.
    task automatic random_batch(int n);
        logic [KEY_W-1:0] k;
        int               added;
        int               r;
        added = 0;
        while (added < n) begin
            k = pick_key();
            if ($urandom_range(99) < 45) begin
                push_req(OP_INSERT, k, pick_pay());
                push_req(OP_SEARCH, k, pick_pay());
                if ($urandom_range(1)) begin
                    push_req(OP_DELETE, k, pick_pay());
                    added++;
                end
                push_req(OP_SEARCH, k, pick_pay());
                added += 3;
            end else begin
                r = $urandom_range(99);
                if (r < 25)      push_req(OP_INSERT, k, pick_pay());
                else if (r < 65) push_req(OP_SEARCH, k, pick_pay());
                else if (r < 94) push_req(OP_DELETE, k, pick_pay());
                else             push_req(OP_UNUSED, k, pick_pay());
                added++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [SIZE_W-1:0] sizes[12];
        logic [31:0]       r;

        // multiples of 17 share home slot and step; a few small keys; the rest random, the last all ones
        for (int i = 0; i < POOL_N; i++) begin
            r = $urandom;
            if (i < 8)       key_pool[i] = KEY_W'(i * 17);
            else if (i < 12) key_pool[i] = KEY_W'(i - 8);
            else             key_pool[i] = r[KEY_W-1:0];
        end
        key_pool[POOL_N - 1] = '1;

        sizes = '{7'd2, 7'd5, 7'd16, 7'd17, 7'd33, 7'd127,
                  7'd64, 7'd100, 7'd40, 7'd7, 7'd1, 7'd64};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles a third of the time, receiver most of the time
        send_idle_pct = 33;
        recv_idle_pct = 88;

        // Directed, at the reset size: field extremes, duplicate insert,
        // home-slot and probe hits, both delete flavors, unused opcode.
        push_req(OP_INSERT, '0, '1);
        push_req(OP_INSERT, '1, '0);
        push_req(OP_INSERT, '0, 32'h1234_5678);       // duplicate, goes down the probes
        push_req(OP_SEARCH, '0, '0);                  // home hit, first copy
        push_req(OP_SEARCH, '1, '1);
        push_req(OP_SEARCH, KEY_W'(5), '0);           // never inserted
        push_req(OP_DELETE, '0, '0);                  // home hit: home slot only
        push_req(OP_SEARCH, '0, '0);                  // found, payload cleared
        push_req(OP_INSERT, KEY_W'(17), 32'hA5A5_5A5A); // same home as key 0
        push_req(OP_SEARCH, KEY_W'(17), '0);          // hit on a probe
        push_req(OP_DELETE, KEY_W'(17), '0);          // non-home delete
        push_req(OP_SEARCH, KEY_W'(17), '0);
        push_req(OP_DELETE, KEY_W'(99), '0);          // nothing to delete
        push_req(OP_UNUSED, '1, '1);
        push_req(OP_SEARCH, '1, '0);
        wait_quiet();

        // one slot: second insert finds the table full
        set_size(7'd1);
        push_req(OP_INSERT, KEY_W'(3), 32'hFFFF_0000);
        push_req(OP_INSERT, KEY_W'(4), 32'h0000_FFFF);
        push_req(OP_SEARCH, KEY_W'(3), '0);
        push_req(OP_DELETE, KEY_W'(3), '0);
        push_req(OP_SEARCH, KEY_W'(3), '0);
        wait_quiet();

        // zero behaves as one
        set_size(7'd0);
        push_req(OP_INSERT, KEY_W'(9), 32'h0F0F_0F0F);
        push_req(OP_SEARCH, KEY_W'(3), '0);
        wait_quiet();

        // Random phases over a spread of sizes; the table keeps its contents
        // across size changes, slots past the size just go out of reach.
        foreach (sizes[ph]) begin
            if (ph == 4) begin
                send_idle_pct = 88;
                recv_idle_pct = 33;
            end else if (ph == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // long receiver stall while words keep coming: input backs up
                hold_go = 1'b1;
            end
            set_size(sizes[ph]);
            random_batch(115);
            wait_quiet();
        end

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (n_bad == 0 && answers_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dht_pkg.sv
rtl/dht_ram.sv
rtl/dht_ctrl.sv
rtl/dht_datapath.sv
rtl/double_hash_table.sv
tb/sv/double_hash_table_test.sv
